[design/cmrp_pkg.sv]
// Package for the curtain-motor reply parser: payload structs, frame
// constants and the parse phase type. No dependencies.
`default_nettype none

package cmrp_pkg;

  // Frame constants
  localparam logic [7:0] SYNC_BYTE   = 8'hd8;
  localparam logic [7:0] MODE_MARKER = 8'hca;
  localparam logic [7:0] SPEED_LIMIT = 8'd100;

  // Report kinds
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_MODE = 2'd1;
  localparam logic [1:0] KIND_POS  = 2'd2;

  // Byte position within the frame
  typedef enum logic [3:0] {
    PH_HUNT   = 4'd0,
    PH_ID     = 4'd1,
    PH_CHAN_H = 4'd2,
    PH_CHAN_L = 4'd3,
    PH_SKIP_A = 4'd4,
    PH_SKIP_B = 4'd5,
    PH_SPEED  = 4'd6,
    PH_KIND   = 4'd7,
    PH_STATUS = 4'd8,
    PH_CSUM   = 4'd9,
    PH_DONE   = 4'd10
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } req_t;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [15:0] channel;
    logic [7:0]  rotate_speed;
    logic [1:0]  report_kind;
    logic [7:0]  position;
    logic [7:0]  curtain_mode_status;
    logic [7:0]  motor_status;
    logic        checksum_ok;
  } rpt_t;

endpackage

`default_nettype wire

[design/curtain_motor_reply_parser_unit.sv]
// Curtain-motor reply parser top level: byte-wise frame state and report register.
// Depends on cmrp_pkg.
//
// Report: a byte carrying last_byte gives its report in the cycle after acceptance.
// Throughput: one byte per cycle; the single report register sets the pace, and
//   a byte is taken whenever that register is empty or is being drained.
// Reset: synchronous rst clears the parse state and the report valid flag;
//   the parser also returns to its reset state after every last byte.
`default_nettype none

module curtain_motor_reply_parser_unit
  import cmrp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rpt_valid,
  input  wire logic rpt_ready,
  output rpt_t      rpt
);

  // Parse state
  phase_t      phase, phase_next;
  logic [7:0]  xor_sum, xor_sum_next;
  logic [7:0]  prev_byte;
  logic [7:0]  id_reg, id_reg_next;
  logic [15:0] channel_reg, channel_reg_next;
  logic [7:0]  speed_reg, speed_reg_next;
  logic [1:0]  kind_reg, kind_reg_next;
  logic [7:0]  position_reg, position_reg_next;
  logic [7:0]  mode_status_reg, mode_status_reg_next;
  logic [7:0]  motor_status_reg, motor_status_reg_next;

  logic       accept;
  logic [7:0] b;

  assign b         = req.rx_byte;
  assign req_ready = !rpt_valid || rpt_ready;
  assign accept    = req_valid && req_ready;

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT:   if (b == SYNC_BYTE) phase_next = PH_ID;
      PH_ID:     phase_next = PH_CHAN_H;
      PH_CHAN_H: phase_next = PH_CHAN_L;
      PH_CHAN_L: phase_next = PH_SKIP_A;
      PH_SKIP_A: phase_next = PH_SKIP_B;
      PH_SKIP_B: phase_next = PH_SPEED;
      PH_SPEED:  phase_next = PH_KIND;
      PH_KIND: begin
        if (b == MODE_MARKER || prev_byte <= SPEED_LIMIT) phase_next = PH_STATUS;
        else                                               phase_next = PH_HUNT;
      end
      PH_STATUS: phase_next = PH_CSUM;
      PH_CSUM:   if (b == xor_sum) phase_next = PH_DONE;
      default:   phase_next = phase;
    endcase
  end

  // Captured fields and running XOR
  always_comb begin
    xor_sum_next          = xor_sum;
    id_reg_next           = id_reg;
    channel_reg_next      = channel_reg;
    speed_reg_next        = speed_reg;
    kind_reg_next         = kind_reg;
    position_reg_next     = position_reg;
    mode_status_reg_next  = mode_status_reg;
    motor_status_reg_next = motor_status_reg;
    unique case (phase)
      PH_HUNT: ;
      PH_ID: begin
        xor_sum_next = xor_sum ^ b;
        id_reg_next  = b;
      end
      PH_CHAN_H: begin
        xor_sum_next     = xor_sum ^ b;
        channel_reg_next = {8'd0, b};
      end
      PH_CHAN_L: begin
        xor_sum_next     = xor_sum ^ b;
        channel_reg_next = {channel_reg[7:0], b};
      end
      PH_SKIP_A, PH_SKIP_B: xor_sum_next = xor_sum ^ b;
      PH_SPEED: begin
        xor_sum_next   = xor_sum ^ b;
        speed_reg_next = b;
      end
      PH_KIND: begin
        xor_sum_next = xor_sum ^ b;
        if (b == MODE_MARKER) begin
          kind_reg_next = KIND_MODE;
        end else if (prev_byte <= SPEED_LIMIT) begin
          position_reg_next = b;
          kind_reg_next     = KIND_POS;
        end
      end
      PH_STATUS: begin
        xor_sum_next = xor_sum ^ b;
        if (prev_byte == MODE_MARKER)      mode_status_reg_next  = b;
        else if (prev_byte <= SPEED_LIMIT) motor_status_reg_next = b;
      end
      default: ;
    endcase
  end

  // Advance parse state; clear it after the last byte
  always_ff @(posedge clk) begin
    if (rst || (accept && req.last_byte)) begin
      phase            <= PH_HUNT;
      xor_sum          <= '0;
      prev_byte        <= '0;
      id_reg           <= '0;
      channel_reg      <= '0;
      speed_reg        <= '0;
      kind_reg         <= KIND_NONE;
      position_reg     <= '0;
      mode_status_reg  <= '0;
      motor_status_reg <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      xor_sum          <= xor_sum_next;
      prev_byte        <= b;
      id_reg           <= id_reg_next;
      channel_reg      <= channel_reg_next;
      speed_reg        <= speed_reg_next;
      kind_reg         <= kind_reg_next;
      position_reg     <= position_reg_next;
      mode_status_reg  <= mode_status_reg_next;
      motor_status_reg <= motor_status_reg_next;
    end
  end

  // Report register: load on the last byte, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rpt_valid <= 1'b0;
    end else if (accept && req.last_byte) begin
      rpt_valid <= 1'b1;
    end else if (rpt_ready) begin
      rpt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && req.last_byte) begin
      rpt.device_id           <= id_reg_next;
      rpt.channel             <= channel_reg_next;
      rpt.rotate_speed        <= speed_reg_next;
      rpt.report_kind         <= kind_reg_next;
      rpt.position            <= position_reg_next;
      rpt.curtain_mode_status <= mode_status_reg_next;
      rpt.motor_status        <= motor_status_reg_next;
      rpt.checksum_ok         <= (phase_next == PH_DONE);
    end
  end

  // Checks
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    accept && req.last_byte |=> phase == PH_HUNT && xor_sum == 8'd0 && kind_reg == KIND_NONE)
    else $error("parse state not cleared after last byte");

  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !req.last_byte && phase == PH_DONE |=> phase == PH_DONE)
    else $error("completed frame left its final phase");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> rpt.report_kind != 2'd3)
    else $error("illegal report kind");

  a_ok_needs_csum: assert property (@(posedge clk) disable iff (rst)
    accept && req.last_byte && phase != PH_CSUM && phase != PH_DONE |=> !rpt.checksum_ok)
    else $error("checksum flagged good without a checksum byte");

endmodule

`default_nettype wire

[dv/tb_curtain_motor_reply_parser_unit.sv]
// Testbench for curtain_motor_reply_parser_unit: a directed table of reply bytes, then
// random reply buffers, checked against a byte-wise frame predictor or typed rows.
// Depends on cmrp_pkg and the parser top level.
`timescale 1ns / 1ps

module tb_curtain_motor_reply_parser_unit;
  import cmrp_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 9;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 470;
  localparam int SHOWN_LIMIT     = 10;
  localparam int DRAIN_CYCLES    = 8;

  // Parser state as the predictor keeps it
  typedef struct packed {
    phase_t      phase;
    logic [7:0]  xsum;
    logic [7:0]  prev;
    logic [7:0]  id;
    logic [15:0] chan;
    logic [7:0]  speed;
    logic [1:0]  kind;
    logic [7:0]  pos;
    logic [7:0]  mode_stat;
    logic [7:0]  motor_stat;
  } frame_state_t;

  typedef struct {
    logic [7:0] rx;
    logic       last;
    bit         typed;
    rpt_t       want;
  } dir_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rpt_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rpt_valid;
  rpt_t rpt;

  frame_state_t frame_state = '0;
  rpt_t         expected_reports[$];
  dir_row_t     dir_rows[$];
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           items_sent    = 0;
  int           mismatches    = 0;
  int           cycles        = 0;

  // Buffer assembly: one byte is held back so the last one can carry last_byte
  logic [7:0] held_byte;
  bit         holding;
  bit         buf_stop;
  int         buf_count;
  int         buf_cut;

  curtain_motor_reply_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt)
  );

  always #HALF_PERIOD clk = ~clk;

  // Advance the frame state by one received byte
  function automatic frame_state_t parse_advance(frame_state_t s, logic [7:0] b);
    case (s.phase)
      PH_HUNT: begin
        if (b == SYNC_BYTE) s.phase = PH_ID;
      end
      PH_ID: begin
        s.xsum ^= b; s.id = b; s.phase = PH_CHAN_H;
      end
      PH_CHAN_H: begin
        s.xsum ^= b; s.chan = {8'h00, b}; s.phase = PH_CHAN_L;
      end
      PH_CHAN_L: begin
        s.xsum ^= b; s.chan = {s.chan[7:0], b}; s.phase = PH_SKIP_A;
      end
      PH_SKIP_A: begin
        s.xsum ^= b; s.phase = PH_SKIP_B;
      end
      PH_SKIP_B: begin
        s.xsum ^= b; s.phase = PH_SPEED;
      end
      PH_SPEED: begin
        s.xsum ^= b; s.speed = b; s.phase = PH_KIND;
      end
      PH_KIND: begin
        s.xsum ^= b;
        s.phase = PH_STATUS;
        if (b == MODE_MARKER) begin
          s.kind = KIND_MODE;
        end else if (s.prev <= SPEED_LIMIT) begin
          s.pos  = b;
          s.kind = KIND_POS;
        end else begin
          s.phase = PH_HUNT;
        end
      end
      PH_STATUS: begin
        s.xsum ^= b;
        if (s.prev == MODE_MARKER) s.mode_stat = b;
        else if (s.prev <= SPEED_LIMIT) s.motor_stat = b;
        s.phase = PH_CSUM;
      end
      PH_CSUM: begin
        if (b == s.xsum) s.phase = PH_DONE;
      end
      default: begin
      end
    endcase
    s.prev = b;
    return s;
  endfunction

  // Offer one byte, wait for acceptance, then predict its report
  task automatic send_byte(input logic [7:0] b, input logic l, input bit typed,
                           input rpt_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= '{rx_byte: b, last_byte: l};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
    frame_state = parse_advance(frame_state, b);
    if (l) begin
      if (typed) begin
        expected_reports.push_back(want);
      end else begin
        expected_reports.push_back('{device_id:           frame_state.id,
                                     channel:             frame_state.chan,
                                     rotate_speed:        frame_state.speed,
                                     report_kind:         frame_state.kind,
                                     position:            frame_state.pos,
                                     curtain_mode_status: frame_state.mode_stat,
                                     motor_status:        frame_state.motor_stat,
                                     checksum_ok:         frame_state.phase == PH_DONE});
      end
      frame_state = '0;
    end
  endtask

  task automatic add_row(input logic [7:0] b, input logic l, input bit typed = 1'b0,
                         input rpt_t want = '0);
    dir_row_t row;
    row.rx    = b;
    row.last  = l;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endtask

  // Queue a byte of the current buffer; send the one held before it
  task automatic queue_byte(input logic [7:0] b);
    if (buf_stop) return;
    if (holding) send_byte(held_byte, 1'b0, 1'b0, '0);
    held_byte = b;
    holding   = 1'b1;
    buf_count++;
    if (buf_cut != 0 && buf_count == buf_cut) buf_stop = 1'b1;
  endtask

  // One random reply buffer: mostly well-formed frames, some noise and cut frames
  task automatic gen_buffer();
    int         n_frames;
    int         r;
    logic [7:0] cs;
    holding   = 1'b0;
    buf_stop  = 1'b0;
    buf_count = 0;
    buf_cut   = 0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) queue_byte(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(99) < 15) buf_cut = $urandom_range(1, 14);
      n_frames = ($urandom_range(3) == 0) ? 2 : 1;
      repeat (n_frames) begin
        repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
        queue_byte(SYNC_BYTE);
        repeat (5) queue_byte(8'($urandom_range(255)));
        // speed: favour the limit and just above it
        r = $urandom_range(9);
        if (r < 4) queue_byte(8'($urandom_range(100)));
        else if (r == 4) queue_byte(SPEED_LIMIT);
        else if (r == 5) queue_byte(SPEED_LIMIT + 8'd1);
        else queue_byte(8'($urandom_range(255)));
        // mode marker or position
        r = $urandom_range(9);
        if (r < 4) queue_byte(MODE_MARKER);
        else if (r == 4) queue_byte(8'($urandom_range(100)));
        else queue_byte(8'($urandom_range(255)));
        queue_byte(8'($urandom_range(255)));
        // checksum: the held status byte still has to be folded in
        cs = parse_advance(frame_state, held_byte).xsum;
        r = $urandom_range(3);
        if (r == 0) begin
          queue_byte(cs ^ 8'($urandom_range(1, 255)));
          if ($urandom_range(1) == 1) queue_byte(cs);
        end else begin
          queue_byte(cs);
        end
      end
      repeat ($urandom_range(2)) queue_byte(8'($urandom_range(255)));
    end
    send_byte(held_byte, 1'b1, 1'b0, '0);
  endtask

  // Receiver: random stalls, and compare each accepted report with the oldest expectation
  always @(posedge clk) begin
    rpt_t want;
    if (rst) begin
      rpt_ready <= 1'b0;
    end else begin
      if (rpt_valid && rpt_ready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_LIMIT)
            $display("unexpected report: id=%h ch=%h spd=%h kind=%0d pos=%h mst=%h sts=%h ok=%b",
                     rpt.device_id, rpt.channel, rpt.rotate_speed, rpt.report_kind,
                     rpt.position, rpt.curtain_mode_status, rpt.motor_status,
                     rpt.checksum_ok);
        end else begin
          want = expected_reports.pop_front();
          if (rpt.device_id !== want.device_id || rpt.channel !== want.channel ||
              rpt.rotate_speed !== want.rotate_speed ||
              rpt.report_kind !== want.report_kind || rpt.position !== want.position ||
              rpt.curtain_mode_status !== want.curtain_mode_status ||
              rpt.motor_status !== want.motor_status ||
              rpt.checksum_ok !== want.checksum_ok) begin
            mismatches++;
            if (mismatches <= SHOWN_LIMIT) begin
              $display("report mismatch at %0t", $realtime);
              $display("  exp id=%h ch=%h spd=%h kind=%0d pos=%h mst=%h sts=%h ok=%b",
                       want.device_id, want.channel, want.rotate_speed, want.report_kind,
                       want.position, want.curtain_mode_status, want.motor_status,
                       want.checksum_ok);
              $display("  got id=%h ch=%h spd=%h kind=%0d pos=%h mst=%h sts=%h ok=%b",
                       rpt.device_id, rpt.channel, rpt.rotate_speed, rpt.report_kind,
                       rpt.position, rpt.curtain_mode_status, rpt.motor_status,
                       rpt.checksum_ok);
            end
          end
        end
      end
      rpt_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("curtain_motor_reply_parser_unit test failed");
      $finish;
    end
  end

  initial begin
    // Directed table: reset report, a fast-speed mode reply with a wrong then a right
    // checksum, an aborted position reply, and a buffer that ends mid-frame
    add_row(8'h00, 1'b1, 1'b1, '0);
    add_row(SYNC_BYTE, 1'b0);
    add_row(8'h01, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hff, 1'b0);
    add_row(8'h65, 1'b0);
    add_row(MODE_MARKER, 1'b0);
    add_row(8'h5a, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hf4, 1'b0);
    add_row(8'h33, 1'b1);
    add_row(SYNC_BYTE, 1'b0);
    add_row(8'h10, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hc8, 1'b0);
    add_row(8'h05, 1'b0);
    add_row(8'h00, 1'b1, 1'b1,
            '{8'h10, 16'h0000, 8'hc8, KIND_NONE, 8'h00, 8'h00, 8'h00, 1'b0});
    add_row(SYNC_BYTE, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h01, 1'b1, 1'b1,
            '{8'h00, 16'h0001, 8'h00, KIND_NONE, 8'h00, 8'h00, 8'h00, 1'b0});

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Sender idles lightly, receiver heavily
    send_idle_pct = 21;
    recv_idle_pct = 49;
    foreach (dir_rows[i])
      send_byte(dir_rows[i].rx, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].want);
    while (items_sent < ITEMS_PER_PHASE) gen_buffer();

    // Swap the pressure
    send_idle_pct = 49;
    recv_idle_pct = 21;
    while (items_sent < 2 * ITEMS_PER_PHASE) gen_buffer();

    // Full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    while (items_sent < 3 * ITEMS_PER_PHASE) gen_buffer();
    req_valid <= 1'b0;

    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("curtain_motor_reply_parser_unit test passed");
    end else begin
      $display("curtain_motor_reply_parser_unit test failed");
    end
    $finish;
  end

endmodule

[files.f]
design/cmrp_pkg.sv
design/curtain_motor_reply_parser_unit.sv
dv/tb_curtain_motor_reply_parser_unit.sv
